FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// clock edge and is switched off while the synchronous reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every sampled edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/blr_pkg.sv
package blr_pkg;

    // Number format and block limits.
    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 12;
    localparam int MAX_BLOCK   = 4096;
    localparam int LEN_W       = 13;
    localparam int STEP_W      = 28;
    localparam int PHASE_W     = LEN_W + FRAC_BITS;
    localparam int OUT_W       = 16;

    // Blend datapath widths.
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam int ACC_W  = SAMPLE_BITS + FRAC_BITS + 2;

    // Register port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Register reset values.
    localparam logic [LEN_W-1:0]  IN_LEN_RST     = LEN_W'(2100);
    localparam logic [LEN_W-1:0]  OUT_LEN_RST    = LEN_W'(2048);
    localparam logic [STEP_W-1:0] STEP_RATIO_RST = STEP_W'(67200);

    // Register index, taken from the word address.
    typedef enum logic [1:0] {
        REG_IN_LEN     = 2'd0,
        REG_OUT_LEN    = 2'd1,
        REG_STEP_RATIO = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [LEN_W-1:0]  in_len;
        logic [LEN_W-1:0]  out_len;
        logic [STEP_W-1:0] step_ratio;
    } t_cfg;

    // One interpolation job handed from the front to the back.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] prev_i;
        logic signed [SAMPLE_BITS-1:0] prev_q;
        logic signed [SAMPLE_BITS-1:0] cur_i;
        logic signed [SAMPLE_BITS-1:0] cur_q;
        logic [FRAC_BITS-1:0]          frac;
        logic                          last;
    } t_blend_req;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [FIFO_CW-1:0] count;
    } t_fifo_status;

endpackage

FILE: sv/blr_regs.sv
module blr_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [blr_pkg::ADDR_W-1:0] paddr,
    input  logic [blr_pkg::DATA_W-1:0] pwdata,
    output logic [blr_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output blr_pkg::t_cfg              o_cfg
);
    import blr_pkg::*;

    logic [LEN_W-1:0]  r_in_len;
    logic [LEN_W-1:0]  r_out_len;
    logic [STEP_W-1:0] r_step_ratio;
    t_reg_idx          w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_len     <= IN_LEN_RST;
            r_out_len    <= OUT_LEN_RST;
            r_step_ratio <= STEP_RATIO_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_IN_LEN:     r_in_len     <= pwdata[LEN_W-1:0];
                REG_OUT_LEN:    r_out_len    <= pwdata[LEN_W-1:0];
                REG_STEP_RATIO: r_step_ratio <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (w_idx)
            REG_IN_LEN:     prdata = DATA_W'(r_in_len);
            REG_OUT_LEN:    prdata = DATA_W'(r_out_len);
            REG_STEP_RATIO: prdata = DATA_W'(r_step_ratio);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.in_len     = r_in_len;
    assign o_cfg.out_len    = r_out_len;
    assign o_cfg.step_ratio = r_step_ratio;

endmodule

FILE: sv/blr_front.sv
module blr_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  blr_pkg::t_cfg                   i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [blr_pkg::SAMPLE_BITS-1:0] i_sample_i,
    input  logic [blr_pkg::SAMPLE_BITS-1:0] i_sample_q,
    input  logic                            i_fifo_full,
    output logic                            o_push,
    output blr_pkg::t_blend_req             o_req
);
    import blr_pkg::*;

    localparam logic [STEP_W-1:0]  STEP_ONE  = STEP_W'(1) << FRAC_BITS;
    localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_BLOCK);
    localparam logic [PHASE_W-1:0] PHASE_SAT = '1;

    logic signed [SAMPLE_BITS-1:0] r_prev_i, n_prev_i;
    logic signed [SAMPLE_BITS-1:0] r_prev_q, n_prev_q;
    logic [LEN_W-1:0]              r_position, n_position;
    logic [PHASE_W-1:0]            r_phase_acc, n_phase_acc;
    logic [LEN_W-1:0]              r_out_count, n_out_count;

    logic [LEN_W-1:0]   w_len;
    logic [LEN_W-1:0]   w_olen;
    logic [STEP_W-1:0]  w_step;
    logic [LEN_W-1:0]   w_base;
    logic               w_hit;
    logic               w_accept;
    logic               w_first;
    logic               w_emit;
    logic               w_end;
    logic [PHASE_W:0]   w_phase_sum;

    // Effective block lengths and step after clamping.
    always_comb begin
        priority if (i_cfg.in_len == '0)     w_len = LEN_W'(1);
        else if (i_cfg.in_len > LEN_MAX)     w_len = LEN_MAX;
        else                                 w_len = i_cfg.in_len;
        w_olen = (i_cfg.out_len > LEN_MAX) ? LEN_MAX : i_cfg.out_len;
        w_step = (i_cfg.step_ratio < STEP_ONE) ? STEP_ONE : i_cfg.step_ratio;
    end

    // Classify the incoming sample.
    assign o_in_stall  = i_fifo_full;
    assign w_accept    = i_in_valid && !i_fifo_full;
    assign w_first     = (r_position == '0);
    assign w_base      = r_phase_acc[PHASE_W-1 -: LEN_W];
    assign w_hit       = (({1'b0, w_base} + (LEN_W+1)'(1)) == {1'b0, r_position});
    assign w_emit      = w_accept && !w_first && (r_out_count < w_olen) && w_hit;
    assign w_end       = (r_position >= w_len);
    assign w_phase_sum = {1'b0, r_phase_acc} + (PHASE_W+1)'(w_step);

    // Block position, phase and output count.
    always_comb begin
        n_prev_i    = r_prev_i;
        n_prev_q    = r_prev_q;
        n_position  = r_position;
        n_phase_acc = r_phase_acc;
        n_out_count = r_out_count;
        if (w_accept) begin
            n_prev_i = i_sample_i;
            n_prev_q = i_sample_q;
            if (w_first) begin
                n_position = LEN_W'(1);
            end else begin
                if (w_emit) begin
                    n_phase_acc = w_phase_sum[PHASE_W] ? PHASE_SAT
                                                       : w_phase_sum[PHASE_W-1:0];
                    n_out_count = r_out_count + LEN_W'(1);
                end
                if (w_end) begin
                    n_phase_acc = '0;
                    n_out_count = '0;
                    n_position  = LEN_W'(1);
                end else begin
                    n_position = r_position + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_i    <= '0;
            r_prev_q    <= '0;
            r_position  <= '0;
            r_phase_acc <= '0;
            r_out_count <= '0;
        end else begin
            r_prev_i    <= n_prev_i;
            r_prev_q    <= n_prev_q;
            r_position  <= n_position;
            r_phase_acc <= n_phase_acc;
            r_out_count <= n_out_count;
        end
    end

    // Job for the back end.
    assign o_push       = w_emit;
    assign o_req.prev_i = r_prev_i;
    assign o_req.prev_q = r_prev_q;
    assign o_req.cur_i  = i_sample_i;
    assign o_req.cur_q  = i_sample_q;
    assign o_req.frac   = r_phase_acc[FRAC_BITS-1:0];
    assign o_req.last   = (({1'b0, r_out_count} + (LEN_W+1)'(1)) == {1'b0, w_olen});

endmodule

FILE: sv/blr_fifo.sv
module blr_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  blr_pkg::t_blend_req    i_data,
    input  logic                   i_pop,
    output blr_pkg::t_blend_req    o_head,
    output blr_pkg::t_fifo_status  o_status
);
    import blr_pkg::*;

    localparam logic [FIFO_AW-1:0] PTR_LAST = FIFO_AW'(FIFO_DEPTH - 1);

    t_blend_req         r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    // Storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + FIFO_AW'(1);
            end
            priority if (i_push && !i_pop) r_count <= r_count + FIFO_CW'(1);
            else if (i_pop && !i_push)     r_count <= r_count - FIFO_CW'(1);
            else                           r_count <= r_count;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_status.count = r_count;

endmodule

FILE: sv/blr_back.sv
module blr_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  blr_pkg::t_blend_req                 i_req,
    output logic                                o_pop,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [blr_pkg::OUT_W-1:0]    o_out_i,
    output logic signed [blr_pkg::OUT_W-1:0]    o_out_q,
    output logic                                o_block_last
);
    import blr_pkg::*;

    localparam int SHIFT = OUT_W - SAMPLE_BITS;
    localparam int T_W   = ACC_W + SHIFT;
    localparam int R_W   = T_W - FRAC_BITS;
    localparam logic signed [T_W-1:0] HALF   = T_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [R_W-1:0] SAT_HI = R_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [R_W-1:0] SAT_LO = -R_W'(1 << (OUT_W - 1));

    // Difference times fraction: prev + (cur - prev) * frac is the blend.
    function automatic logic signed [PROD_W-1:0] diff_prod(
        input logic signed [SAMPLE_BITS-1:0] prev,
        input logic signed [SAMPLE_BITS-1:0] cur,
        input logic [FRAC_BITS-1:0]          frac
    );
        logic signed [DIFF_W-1:0] d;
        logic signed [FRAC_BITS:0] f;
        d = DIFF_W'(cur) - DIFF_W'(prev);
        f = signed'({1'b0, frac});
        return PROD_W'(d) * PROD_W'(f);
    endfunction

    // Scale to the output unit, round half up and saturate.
    function automatic logic signed [OUT_W-1:0] round_sat(
        input logic signed [SAMPLE_BITS-1:0] base,
        input logic signed [PROD_W-1:0]      prod
    );
        logic signed [ACC_W-1:0] acc;
        logic signed [T_W-1:0]   t;
        logic signed [R_W-1:0]   r;
        acc = (ACC_W'(base) <<< FRAC_BITS) + ACC_W'(prod);
        t   = (T_W'(acc) <<< SHIFT) + HALF;
        r   = t[T_W-1:FRAC_BITS];
        priority if (r > SAT_HI) return OUT_W'(SAT_HI);
        else if (r < SAT_LO)     return OUT_W'(SAT_LO);
        else                     return OUT_W'(r);
    endfunction

    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_base_i;
    logic signed [SAMPLE_BITS-1:0] r_s1_base_q;
    logic signed [PROD_W-1:0]      r_s1_prod_i;
    logic signed [PROD_W-1:0]      r_s1_prod_q;
    logic                          r_s1_last;
    logic                          r_out_valid;
    logic signed [OUT_W-1:0]       r_out_i;
    logic signed [OUT_W-1:0]       r_out_q;
    logic                          r_out_last;
    logic                          w_out_free;
    logic                          w_s1_free;

    // A stage may load when it is empty or its word moves on this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign o_pop      = i_valid && w_s1_free;

    // Multiply stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_base_i <= i_req.prev_i;
            r_s1_base_q <= i_req.prev_q;
            r_s1_prod_i <= diff_prod(i_req.prev_i, i_req.cur_i, i_req.frac);
            r_s1_prod_q <= diff_prod(i_req.prev_q, i_req.cur_q, i_req.frac);
            r_s1_last   <= i_req.last;
        end
    end

    // Round and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_out_i    <= round_sat(r_s1_base_i, r_s1_prod_i);
            r_out_q    <= round_sat(r_s1_base_q, r_s1_prod_q);
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_i      = r_out_i;
    assign o_out_q      = r_out_q;
    assign o_block_last = r_out_last;

endmodule

FILE: sv/block_linear_resampler.sv
// Block linear resampler: converts a stream of 12-bit I/Q samples to a new
// rate by linear interpolation, in blocks of in_len new samples and out_len
// outputs, stepping step_ratio (Q16) input positions per output and
// flagging the last output of each block with block_last. One sample word
// is accepted per clock while input stall is low; the front tracks block
// position and phase for each sample and queues each output job in a
// four-word queue. The back blends one job per clock while the output is
// not stalled, through a multiply stage and a round/saturate output
// register. Input stall rises only when the queue is full, which takes an
// output stall long enough to back up the back end and the queue; it stays
// high until the back end pops a job after the output stall ends. The user
// must write the registers over the APB port only while the block is idle,
// which the block itself does not enforce; they take effect at once.
`include "assert_macros.svh"

module block_linear_resampler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [blr_pkg::ADDR_W-1:0]         paddr,
    input  logic [blr_pkg::DATA_W-1:0]         pwdata,
    output logic [blr_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [blr_pkg::SAMPLE_BITS-1:0] i_sample_i,
    input  logic signed [blr_pkg::SAMPLE_BITS-1:0] i_sample_q,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [blr_pkg::OUT_W-1:0]   o_out_i,
    output logic signed [blr_pkg::OUT_W-1:0]   o_out_q,
    output logic                               o_block_last
);
    import blr_pkg::*;

    t_cfg         w_cfg;
    t_blend_req   w_push_req;
    t_blend_req   w_head;
    t_fifo_status w_fifo_st;
    logic         w_push;
    logic         w_pop;

    blr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    blr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_i  (i_sample_i),
        .i_sample_q  (i_sample_q),
        .i_fifo_full (w_fifo_st.full),
        .o_push      (w_push),
        .o_req       (w_push_req)
    );

    blr_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_req),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_fifo_st)
    );

    blr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (!w_fifo_st.empty),
        .i_req        (w_head),
        .o_pop        (w_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_i      (o_out_i),
        .o_out_q      (o_out_q),
        .o_block_last (o_block_last)
    );

    // Queue integrity checks.
    `ASSERT_ALWAYS(a_fifo_bound, w_fifo_st.count <= FIFO_CW'(FIFO_DEPTH), "queue count above depth")
    `ASSERT_IMPLY(a_no_push_full, w_push, !w_fifo_st.full, "job pushed into a full queue")
    `ASSERT_IMPLY(a_no_pop_empty, w_pop, !w_fifo_st.empty, "job popped from an empty queue")

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    import blr_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RAND_ITEMS    = 1200;
    localparam int STEADY_FROM   = 1050;
    localparam longint PHASE_TOP = (longint'(1) << PHASE_W) - 1;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = ~SMP_MIN;

    // One output word of the resampler.
    typedef struct packed {
        logic signed [OUT_W-1:0] out_i;
        logic signed [OUT_W-1:0] out_q;
        logic                    block_last;
    } t_resample_out;

    // One row of the directed sequence: a register write or a sample word.
    typedef struct {
        bit                            is_cfg;
        t_reg_idx                      idx;
        logic [DATA_W-1:0]             val;
        logic signed [SAMPLE_BITS-1:0] si;
        logic signed [SAMPLE_BITS-1:0] sq;
        bit                            typed;
        t_resample_out                 want;
    } t_dir_row;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [ADDR_W-1:0]             paddr        = '0;
    logic [DATA_W-1:0]             pwdata       = '0;
    wire  [DATA_W-1:0]             prdata;
    wire                           pready;
    logic                          i_in_valid   = 1'b0;
    wire                           o_in_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample_i   = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_q   = '0;
    wire                           o_out_valid;
    logic                          i_out_stall  = 1'b0;
    wire signed [OUT_W-1:0]        o_out_i;
    wire signed [OUT_W-1:0]        o_out_q;
    wire                           o_block_last;

    // Predictor copy of the registers and of the block state.
    logic [LEN_W-1:0]              cfg_in_len  = IN_LEN_RST;
    logic [LEN_W-1:0]              cfg_out_len = OUT_LEN_RST;
    logic [STEP_W-1:0]             cfg_step    = STEP_RATIO_RST;
    logic signed [SAMPLE_BITS-1:0] hist_i      = '0;
    logic signed [SAMPLE_BITS-1:0] hist_q      = '0;
    logic [LEN_W-1:0]              blk_pos     = '0;
    logic [PHASE_W-1:0]            out_phase   = '0;
    logic [LEN_W-1:0]              blk_outs    = '0;

    t_resample_out resampled_due[$];
    t_dir_row      dir_rows[$];
    int            n_err          = 0;
    int            cycle_cnt      = 0;
    int            stall_left     = 0;
    int            src_gap_pct    = 0;
    int            sink_stall_pct = 0;
    bit            steady_tail    = 1'b0;

    block_linear_resampler i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_i   (i_sample_i),
        .i_sample_q   (i_sample_q),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_i      (o_out_i),
        .o_out_q      (o_out_q),
        .o_block_last (o_block_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Effective block length after clamping.
    function automatic int unsigned eff_len();
        int unsigned len;
        len = cfg_in_len;
        if (len < 1) len = 1;
        if (len > MAX_BLOCK) len = MAX_BLOCK;
        return len;
    endfunction

    // Linear blend of two samples, scaled to 1/32768 full scale, rounded half up.
    function automatic logic signed [OUT_W-1:0] interp(input logic signed [SAMPLE_BITS-1:0] a,
                                                       input logic signed [SAMPLE_BITS-1:0] b,
                                                       input logic [FRAC_BITS-1:0] f);
        longint unit;
        longint acc;
        longint r;
        unit = longint'(1) << FRAC_BITS;
        acc = longint'(a) * (unit - longint'(f)) + longint'(b) * longint'(f);
        r = ((acc <<< (OUT_W - SAMPLE_BITS)) + (unit >>> 1)) >>> FRAC_BITS;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return OUT_W'(r);
    endfunction

    // Advance the block state by one sample; returns 1 when an output word falls due.
    function automatic bit interp_next(input logic signed [SAMPLE_BITS-1:0] ci,
                                       input logic signed [SAMPLE_BITS-1:0] cq,
                                       output t_resample_out r);
        int unsigned len;
        int unsigned olen;
        int unsigned base;
        int unsigned p;
        longint      step;
        longint      nxt;
        bit          hit;
        hit = 1'b0;
        r = '0;
        len = eff_len();
        olen = cfg_out_len;
        if (olen > MAX_BLOCK) olen = MAX_BLOCK;
        step = cfg_step;
        if (step < (longint'(1) << FRAC_BITS)) step = longint'(1) << FRAC_BITS;
        p = blk_pos;
        if (p == 0) begin
            blk_pos = 1;
        end else begin
            base = out_phase >> FRAC_BITS;
            if (blk_outs < olen && base + 1 == p) begin
                r.out_i = interp(hist_i, ci, out_phase[FRAC_BITS-1:0]);
                r.out_q = interp(hist_q, cq, out_phase[FRAC_BITS-1:0]);
                r.block_last = (blk_outs + 1 == olen);
                hit = 1'b1;
                nxt = longint'(out_phase) + step;
                if (nxt > PHASE_TOP) nxt = PHASE_TOP;
                out_phase = PHASE_W'(nxt);
                blk_outs = blk_outs + 1'b1;
            end
            if (p >= len) begin
                out_phase = '0;
                blk_outs = '0;
                blk_pos = 1;
            end else begin
                blk_pos = LEN_W'(p + 1);
            end
        end
        hist_i = ci;
        hist_q = cq;
        return hit;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SMP_MIN;
            1: return SMP_MAX;
            2: return '0;
            3: return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic t_dir_row cfg_row(input t_reg_idx idx, input int unsigned val);
        t_dir_row row;
        row = '{idx: REG_IN_LEN, default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.val = val;
        return row;
    endfunction

    function automatic t_dir_row smp_row(input int si, input int sq);
        t_dir_row row;
        row = '{idx: REG_IN_LEN, default: '0};
        row.si = SAMPLE_BITS'(si);
        row.sq = SAMPLE_BITS'(sq);
        return row;
    endfunction

    // Sample row whose output word is known by inspection.
    function automatic t_dir_row chk_row(input int si, input int sq, input int ei, input int eq,
                                         input bit el);
        t_dir_row row;
        row = smp_row(si, sq);
        row.typed = 1'b1;
        row.want.out_i = OUT_W'(ei);
        row.want.out_q = OUT_W'(eq);
        row.want.block_last = el;
        return row;
    endfunction

    // Register write over APB, only once the block has gone idle.
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] val);
        i_in_valid <= 1'b0;
        while (resampled_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IN_LEN:     cfg_in_len  = val[LEN_W-1:0];
            REG_OUT_LEN:    cfg_out_len = val[LEN_W-1:0];
            REG_STEP_RATIO: cfg_step    = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one sample word, with an optional random gap, and predict its output.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] si,
                               input logic signed [SAMPLE_BITS-1:0] sq,
                               input bit typed, input t_resample_out want);
        t_resample_out got;
        bit            hit;
        if (!steady_tail && $urandom_range(0, 99) < src_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_i <= si;
        i_sample_q <= sq;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        hit = interp_next(si, sq, got);
        if (typed) begin
            if (!hit) begin
                n_err++;
                $display("%0t: directed word expects an output but the block state gives none",
                         $time);
            end
            resampled_due.push_back(want);
        end else if (hit) begin
            resampled_due.push_back(got);
        end
    endtask

    // Output stall in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n || steady_tail) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (stall_left == 0 && $urandom_range(0, 99) < sink_stall_pct)
                stall_left = $urandom_range(1, 10);
            i_out_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    // Compare each accepted output word with the oldest predicted one.
    always @(posedge i_clk) begin : out_check
        t_resample_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (resampled_due.size() == 0) begin
                n_err++;
                $display("%0t: output word with none due: i=%0d q=%0d last=%0d",
                         $time, o_out_i, o_out_q, o_block_last);
            end else begin
                want = resampled_due.pop_front();
                if (o_out_i !== want.out_i) begin
                    n_err++;
                    $display("%0t: out_i expected %0d got %0d", $time, want.out_i, o_out_i);
                end
                if (o_out_q !== want.out_q) begin
                    n_err++;
                    $display("%0t: out_q expected %0d got %0d", $time, want.out_q, o_out_q);
                end
                if (o_block_last !== want.block_last) begin
                    n_err++;
                    $display("%0t: block_last expected %0d got %0d",
                             $time, want.block_last, o_block_last);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("block_linear_resampler verification failed");
            $finish;
        end
    end

    initial begin : stim
        t_resample_out none;
        int            rand_items;
        int            phase;
        int unsigned   len;
        int unsigned   ceil_len;
        int unsigned   new_len;
        int unsigned   new_olen;
        int            new_step;
        int unsigned   n_smp;
        bit            long_phase;

        none = '0;
        rand_items = 0;
        phase = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sequence: extreme samples, block end, slow step, fractional
        // positions with outputs past block end, output count reached, short
        // block, zero outputs and a huge step.
        dir_rows.push_back(cfg_row(REG_IN_LEN, 3));
        dir_rows.push_back(cfg_row(REG_OUT_LEN, 3));
        dir_rows.push_back(cfg_row(REG_STEP_RATIO, 65536));
        dir_rows.push_back(smp_row(2047, -2048));
        dir_rows.push_back(chk_row(-2048, 2047, 32752, -32768, 1'b0));
        dir_rows.push_back(chk_row(0, 0, -32768, 32752, 1'b0));
        dir_rows.push_back(chk_row(-1, 1, 0, 0, 1'b1));
        dir_rows.push_back(chk_row(1, -1, -16, 16, 1'b0));
        dir_rows.push_back(chk_row(1365, -683, 16, -16, 1'b0));
        dir_rows.push_back(cfg_row(REG_STEP_RATIO, 32768));
        dir_rows.push_back(chk_row(-1000, 999, 21840, -10928, 1'b1));
        dir_rows.push_back(cfg_row(REG_IN_LEN, 5));
        dir_rows.push_back(cfg_row(REG_OUT_LEN, 8));
        dir_rows.push_back(cfg_row(REG_STEP_RATIO, 81920));
        dir_rows.push_back(smp_row(2047, 2047));
        dir_rows.push_back(smp_row(-2048, -2048));
        dir_rows.push_back(smp_row(1024, -1024));
        dir_rows.push_back(smp_row(-1, 0));
        dir_rows.push_back(smp_row(0, -1));
        dir_rows.push_back(cfg_row(REG_OUT_LEN, 2));
        dir_rows.push_back(smp_row(-2048, 2047));
        dir_rows.push_back(smp_row(2047, -2048));
        dir_rows.push_back(smp_row(555, -555));
        dir_rows.push_back(smp_row(-7, 7));
        dir_rows.push_back(smp_row(1, 1));
        dir_rows.push_back(cfg_row(REG_IN_LEN, 0));
        dir_rows.push_back(cfg_row(REG_OUT_LEN, 1));
        dir_rows.push_back(smp_row(300, -300));
        dir_rows.push_back(smp_row(-300, 300));
        dir_rows.push_back(cfg_row(REG_OUT_LEN, 0));
        dir_rows.push_back(smp_row(12, 34));
        dir_rows.push_back(smp_row(-56, 78));
        dir_rows.push_back(cfg_row(REG_IN_LEN, 4));
        dir_rows.push_back(cfg_row(REG_OUT_LEN, 3));
        dir_rows.push_back(cfg_row(REG_STEP_RATIO, 268435455));
        dir_rows.push_back(smp_row(2047, 0));
        dir_rows.push_back(smp_row(0, 2047));
        dir_rows.push_back(smp_row(-2048, -1));
        dir_rows.push_back(smp_row(-1, -2048));

        src_gap_pct = 20;
        sink_stall_pct = 20;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg)
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            else
                send_sample(dir_rows[r].si, dir_rows[r].sq, dir_rows[r].typed, dir_rows[r].want);
        end

        // Random phases: a new register setting, then whole blocks of random
        // samples, sometimes cut short so that the next setting lands mid-block.
        while (rand_items < RAND_ITEMS) begin
            long_phase = (phase == 3);
            case ($urandom_range(0, 2))
                0: src_gap_pct = 0;
                1: src_gap_pct = 15;
                default: src_gap_pct = 45;
            endcase
            case ($urandom_range(0, 2))
                0: sink_stall_pct = 0;
                1: sink_stall_pct = 15;
                default: sink_stall_pct = 50;
            endcase

            if (long_phase) begin
                // Both lengths above the maximum block, one output per sample.
                write_reg(REG_IN_LEN, 8191);
                write_reg(REG_OUT_LEN, 8191);
                write_reg(REG_STEP_RATIO, 65536);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: new_len = $urandom_range(2, 40);
                    7: new_len = $urandom_range(41, 300);
                    default: new_len = $urandom_range(0, 2);
                endcase
                ceil_len = (new_len == 0) ? 1 : new_len;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: new_olen = $urandom_range(1, ceil_len);
                    7: new_olen = 0;
                    8: new_olen = ceil_len;
                    default: new_olen = $urandom_range(ceil_len, ceil_len + 50);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        if (new_olen == 0)
                            new_step = 65536;
                        else
                            new_step = int'((longint'(ceil_len) << FRAC_BITS) / new_olen)
                                       + $urandom_range(0, 4) - 2;
                    end
                    6, 7: new_step = $urandom_range(0, 65535);
                    8: new_step = $urandom_range(65536, 268435455);
                    default: new_step = 268435455;
                endcase
                if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(REG_IN_LEN, new_len);
                if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(REG_OUT_LEN, new_olen);
                if (phase == 0 || $urandom_range(0, 3) != 0)
                    write_reg(REG_STEP_RATIO, DATA_W'(new_step));
            end

            // Samples up to the end of the current block, then more blocks.
            len = eff_len();
            if (blk_pos == 0) n_smp = len + 1;
            else if (blk_pos >= len) n_smp = 1;
            else n_smp = len - blk_pos + 1;
            if (long_phase) begin
                if (blk_pos != 1) n_smp += len;
            end else begin
                n_smp += len * $urandom_range(0, 3);
                if ($urandom_range(0, 9) < 3) n_smp += $urandom_range(1, len);
            end

            repeat (n_smp) begin
                send_sample(pick_sample(), pick_sample(), 1'b0, none);
                if (!long_phase) rand_items++;
                if (rand_items >= STEADY_FROM) steady_tail = 1'b1;
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        while (resampled_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_err == 0)
            $display("block_linear_resampler verification clean");
        else
            $display("block_linear_resampler verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/blr_pkg.sv
sv/blr_regs.sv
sv/blr_front.sv
sv/blr_fifo.sv
sv/blr_back.sv
sv/block_linear_resampler.sv
tb/sv/tb_top.sv
